FILE: rtl/core/edd_pkg.sv
// Shared types, request codes and sizing constants for the edit distance engine.
package edd_pkg;

   localparam int MAX_LEN_DEFAULT = 256;
   localparam int DIST_W          = 9;
   localparam int DIST_MAX        = 511;

   localparam logic [1:0] REQ_FIRST   = 2'd0;
   localparam logic [1:0] REQ_SECOND  = 2'd1;
   localparam logic [1:0] REQ_COMPUTE = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] ch;
   } edd_req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              too_long;
   } edd_rsp_type;

   typedef struct packed {
      logic load;
      logic start_calc;
      logic row_setup;
      logic cell_step;
      logic store_trivial;
      logic store_full;
   } edd_cmd_type;

   typedef struct packed {
      logic trivial;
      logic row_end;
      logic last_row;
   } edd_status_type;

endpackage

FILE: rtl/core/edit_distance_engine.sv
// Top level of the Levenshtein edit distance engine.
// Append beats (req_type 0 or 1) load one byte per cycle into the first or second string.
// A compute beat (req_type 2) walks the cost matrix through a single cost row memory:
// a row setup step, then one cell per cycle along the row, for every row. req_stall is
// high meanwhile, and the result beat is valid in the cycle after the last cell. If either
// string is empty or overflowed the result beat is valid in the cycle after the compute
// beat. The result beat carries the distance (saturated to 511) and too_long, and both
// strings are cleared. An append beyond MAX_LEN bytes is dropped and flags too_long, with
// distance 0. Beats are also stalled while a result beat is stalled.
module edit_distance_engine import edd_pkg::*; #(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  edd_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output edd_rsp_type rsp_data
);

   edd_cmd_type    cmd;
   edd_status_type status;

   edd_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_code  (req_data.req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   edd_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

FILE: rtl/core/edd_datapath.sv
// Datapath: string stores, cost row memory, cell arithmetic and result register.
module edd_datapath import edd_pkg::*; #(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  edd_req_type    req_data,
   input  edd_cmd_type    cmd,
   output edd_status_type status,
   output edd_rsp_type    rsp_data
);

   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int SAT_W = (LEN_W > DIST_W) ? LEN_W : DIST_W;

   logic [7:0]       first_text  [MAX_LEN];
   logic [7:0]       second_text [MAX_LEN];
   logic [LEN_W-1:0] cost_row    [MAX_LEN];

   logic [LEN_W-1:0] first_count_ff, first_count_in;
   logic [LEN_W-1:0] second_count_ff, second_count_in;
   logic             overflow_ff, overflow_in;
   logic [LEN_W-1:0] i_ff, i_in;
   logic [LEN_W-1:0] j_ff, j_in;
   logic [LEN_W-1:0] left_ff, left_in;
   logic [LEN_W-1:0] diag_ff, diag_in;
   logic [7:0]       ft_rd_ff;
   logic [7:0]       st_rd_ff;
   logic [LEN_W-1:0] cr_rd_ff;
   edd_rsp_type      rsp_ff, rsp_in;

   logic             first_full, second_full;
   logic             wr_first, wr_second;
   logic [IDX_W-1:0] ft_addr, rd_addr, wr_addr;
   logic [LEN_W-1:0] above, min_lu, min_all, cell_val, trivial_val;

   function automatic logic [DIST_W-1:0] saturate(input logic [LEN_W-1:0] v);
      logic [SAT_W-1:0] ext;
      ext = SAT_W'(v);
      if (ext > SAT_W'(DIST_MAX)) begin
         return DIST_W'(DIST_MAX);
      end
      return ext[DIST_W-1:0];
   endfunction

   assign first_full  = (first_count_ff == LEN_W'(MAX_LEN));
   assign second_full = (second_count_ff == LEN_W'(MAX_LEN));
   assign wr_first    = cmd.load && (req_data.req_type == REQ_FIRST) && !first_full;
   assign wr_second   = cmd.load && (req_data.req_type == REQ_SECOND) && !second_full;

   assign ft_addr = IDX_W'(i_ff - LEN_W'(1));
   assign rd_addr = cmd.row_setup ? '0 : j_ff[IDX_W-1:0];
   assign wr_addr = IDX_W'(j_ff - LEN_W'(1));

   // the first row is implicit: above is j, not taken from the cost row
   assign above    = (i_ff == LEN_W'(1)) ? j_ff : cr_rd_ff;
   assign min_lu   = (left_ff < above) ? left_ff : above;
   assign min_all  = (min_lu < diag_ff) ? min_lu : diag_ff;
   assign cell_val = (ft_rd_ff == st_rd_ff) ? diag_ff : min_all + LEN_W'(1);

   assign trivial_val = (first_count_ff == '0) ? second_count_ff : first_count_ff;

   assign status.trivial  = overflow_ff || (first_count_ff == '0) || (second_count_ff == '0);
   assign status.row_end  = (j_ff == second_count_ff);
   assign status.last_row = (i_ff == first_count_ff);

   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      overflow_in     = overflow_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      left_in         = left_ff;
      diag_in         = diag_ff;
      rsp_in          = rsp_ff;
      if (cmd.load) begin
         if (wr_first) begin
            first_count_in = first_count_ff + LEN_W'(1);
         end
         if (wr_second) begin
            second_count_in = second_count_ff + LEN_W'(1);
         end
         if ((req_data.req_type == REQ_FIRST && first_full) ||
             (req_data.req_type == REQ_SECOND && second_full)) begin
            overflow_in = 1'b1;
         end
      end
      if (cmd.start_calc) begin
         i_in = LEN_W'(1);
      end
      if (cmd.row_setup) begin
         j_in    = LEN_W'(1);
         left_in = i_ff;
         diag_in = i_ff - LEN_W'(1);
      end
      if (cmd.cell_step) begin
         j_in    = j_ff + LEN_W'(1);
         left_in = cell_val;
         diag_in = above;
         if (status.row_end) begin
            i_in = i_ff + LEN_W'(1);
         end
      end
      if (cmd.store_trivial) begin
         rsp_in.distance = overflow_ff ? '0 : saturate(trivial_val);
         rsp_in.too_long = overflow_ff;
      end
      if (cmd.store_full) begin
         rsp_in.distance = saturate(cell_val);
         rsp_in.too_long = 1'b0;
      end
      if (cmd.store_trivial || cmd.store_full) begin
         first_count_in  = '0;
         second_count_in = '0;
         overflow_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         overflow_ff     <= 1'b0;
      end else begin
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         overflow_ff     <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      left_ff <= left_in;
      diag_ff <= diag_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_first) begin
         first_text[first_count_ff[IDX_W-1:0]] <= req_data.ch;
      end
      if (cmd.row_setup) begin
         ft_rd_ff <= first_text[ft_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_second) begin
         second_text[second_count_ff[IDX_W-1:0]] <= req_data.ch;
      end
      if (cmd.row_setup || cmd.cell_step) begin
         st_rd_ff <= second_text[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cell_step) begin
         cost_row[wr_addr] <= cell_val;
      end
      if (cmd.row_setup || cmd.cell_step) begin
         cr_rd_ff <= cost_row[rd_addr];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: rtl/core/edd_controller.sv
// Controller: handshakes, row/cell sequencing and result valid.
module edd_controller import edd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic [1:0]     req_code,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  edd_status_type status,
   output edd_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_ROW  = 3'b010,
      ST_CELL = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_accept;

   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_code)
                  REQ_FIRST, REQ_SECOND: cmd.load = 1'b1;
                  REQ_COMPUTE: begin
                     if (status.trivial) begin
                        cmd.store_trivial = 1'b1;
                     end else begin
                        cmd.start_calc = 1'b1;
                        state_in       = ST_ROW;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ROW: begin
            cmd.row_setup = 1'b1;
            state_in      = ST_CELL;
         end
         ST_CELL: begin
            cmd.cell_step = 1'b1;
            if (status.row_end) begin
               if (status.last_row) begin
                  cmd.store_full = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  state_in = ST_ROW;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.store_trivial || cmd.store_full) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_row_to_cell: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROW |=> state_ff == ST_CELL)
      else $error("row setup not followed by cell step");

   a_full_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CELL && status.row_end && status.last_row) |=>
      (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("last cell did not post a result");

   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_code == REQ_COMPUTE && !status.trivial) |=> state_ff == ST_ROW)
      else $error("compute beat did not start the matrix walk");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("stalled result beat dropped");
`endif

endmodule
